// ----- rtl/sfr_pkg.sv -----
// Shared types and constants for the stream find-and-replace block.
// No dependencies; imported by sfr_ctrl, sfr_datapath and the top level.
`default_nettype none

package sfr_pkg;

  localparam int unsigned MAX_PATTERN     = 8;
  localparam int unsigned MAX_REPLACEMENT = 8;
  localparam logic [7:0]  NEWLINE_BYTE    = 8'h0A;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } sfr_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } sfr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // take the accepted item
    logic search;  // test one start position
    logic emit;    // load the next result into the output register
    logic finish;  // commit the held-prefix count
  } sfr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic search_done;
    logic total_zero;
    logic emit_last;
    logic out_free;
  } sfr_status_t;

endpackage

`default_nettype wire

// ----- rtl/sfr_ctrl.sv -----
// Sequencer for the stream find-and-replace block: load, search, emit.
// Depends on sfr_pkg.
`default_nettype none

module sfr_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_fire,
  output logic                in_ready,
  input  sfr_pkg::sfr_status_t status,
  output sfr_pkg::sfr_cmd_t    cmd
);
  import sfr_pkg::*;

  sfr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (status.search_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.total_zero) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/sfr_datapath.sv -----
// Datapath: config registers, held-prefix state, start-position search,
// result sequencing and the output register. Depends on sfr_pkg.
`default_nettype none

module sfr_datapath (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire  [1:0]           cfg_index,
  input  wire  [63:0]          cfg_data,
  input  wire  [7:0]           data_byte,
  input  wire                  end_of_stream,
  input  sfr_pkg::sfr_cmd_t    cmd,
  output sfr_pkg::sfr_status_t status,
  output logic [7:0]           out_byte,
  output logic                 run_last,
  output logic                 stream_last,
  output logic                 out_valid,
  input  wire                  out_ready
);
  import sfr_pkg::*;

  logic [63:0] pat_bytes, rep_bytes;
  logic [3:0]  pat_len_raw, rep_len_raw;
  logic [3:0]  plen, rlen;

  logic [7:0]  byte_r;
  logic        eos_r;
  logic [3:0]  m_r;       // held prefix length for this item
  logic [3:0]  start;     // candidate start, ends as the emitted prefix count
  logic [3:0]  m_new;
  logic        full_r;
  logic [3:0]  matched;   // kept across items
  logic [4:0]  k;         // result index within the item

  logic [3:0]  n, cand_len, m_clamp;
  logic        cand_ok, is_nl;
  logic [4:0]  pre_cnt, rep_cnt, tail_cnt, total, pre_rep;
  logic [4:0]  rel_rep, rel_tail;
  logic [7:0]  emit_byte;

  function automatic logic [3:0] clamp_len(logic [3:0] len, logic [3:0] cap);
    logic [3:0] r;
    if (len == 4'd0)    r = 4'd1;
    else if (len > cap) r = cap;
    else                r = len;
    return r;
  endfunction

  function automatic logic [7:0] byte_of(logic [63:0] w, logic [2:0] i);
    return w[{i, 3'b000} +: 8];
  endfunction

  // held pattern bytes followed by the new byte
  function automatic logic [7:0] buf_byte(logic [3:0] j, logic [3:0] m,
                                          logic [63:0] p, logic [7:0] b);
    logic [7:0] r;
    if (j < m) r = byte_of(p, j[2:0]);
    else       r = b;
    return r;
  endfunction

  assign plen    = clamp_len(pat_len_raw, 4'(MAX_PATTERN));
  assign rlen    = clamp_len(rep_len_raw, 4'(MAX_REPLACEMENT));
  assign m_clamp = (matched >= plen) ? plen - 4'd1 : matched;

  assign n        = m_r + 4'd1;
  assign cand_len = n - start;
  assign is_nl    = (byte_r == NEWLINE_BYTE);

  // one candidate start per cycle: compare the tail against the pattern head
  always_comb begin
    cand_ok = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((4'(i) < cand_len) &&
          (buf_byte(start + 4'(i), m_r, pat_bytes, byte_r) != byte_of(pat_bytes, 3'(i))))
        cand_ok = 1'b0;
    end
  end

  // result sequence: unmatched prefix, replacement, end-of-stream flush
  assign pre_cnt  = {1'b0, start};
  assign rep_cnt  = full_r ? {1'b0, rlen} : 5'd0;
  assign tail_cnt = eos_r ? {1'b0, m_new} : 5'd0;
  assign pre_rep  = pre_cnt + rep_cnt;
  assign total    = pre_rep + tail_cnt;
  assign rel_rep  = k - pre_cnt;
  assign rel_tail = k - pre_rep;

  always_comb begin
    if (k < pre_cnt)      emit_byte = buf_byte(k[3:0], m_r, pat_bytes, byte_r);
    else if (k < pre_rep) emit_byte = byte_of(rep_bytes, rel_rep[2:0]);
    else                  emit_byte = byte_of(pat_bytes, rel_tail[2:0]);
  end

  assign status.search_done = is_nl || cand_ok || (start == m_r);
  assign status.total_zero  = (total == 5'd0);
  assign status.emit_last   = (k == total - 5'd1);
  assign status.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_bytes   <= '0;
      pat_len_raw <= 4'd1;
      rep_bytes   <= '0;
      rep_len_raw <= 4'd1;
    end else if (cfg_we) begin
      unique case (sfr_reg_t'(cfg_index))
        REG_PATTERN_BYTES:      pat_bytes   <= cfg_data;
        REG_PATTERN_LENGTH:     pat_len_raw <= cfg_data[3:0];
        REG_REPLACEMENT_BYTES:  rep_bytes   <= cfg_data;
        REG_REPLACEMENT_LENGTH: rep_len_raw <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matched <= '0;
    end else if (cmd.finish) begin
      matched <= eos_r ? 4'd0 : m_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= data_byte;
      eos_r  <= end_of_stream;
      m_r    <= m_clamp;
      start  <= '0;
      k      <= '0;
    end else if (cmd.search) begin
      if (is_nl) begin
        start  <= n;
        m_new  <= '0;
        full_r <= 1'b0;
      end else if (cand_ok) begin
        full_r <= (cand_len == plen);
        m_new  <= (cand_len == plen) ? 4'd0 : cand_len;
      end else if (start == m_r) begin
        start  <= n;
        m_new  <= '0;
        full_r <= 1'b0;
      end else begin
        start <= start + 4'd1;
      end
    end else if (cmd.emit) begin
      k <= k + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte    <= emit_byte;
      run_last    <= status.emit_last;
      stream_last <= status.emit_last && eos_r;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stream_find_replace_top.sv -----
// Top level of the stream find-and-replace block.
// Depends on sfr_pkg, sfr_ctrl and sfr_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one text byte per item plus
//   end_of_stream on the final byte. Output channel (out_valid/out_ready)
//   carries rewritten bytes; run_last marks the last byte caused by an
//   input item, stream_last the final byte of the whole output.
//   An input byte that may begin a match is held back and yields nothing
//   until the match completes (replacement bytes go out) or fails (held
//   bytes go out unchanged). Newline passes through and cancels a partial
//   match. end_of_stream flushes any held bytes.
// Flow:
//   One item at a time. An item is loaded, then the search unit tries one
//   start position per cycle (1 to pattern length, only one for a newline),
//   then the result bytes (1 to 8) go out one per cycle while the output
//   register is free; an item that yields nothing goes straight to idle.
//   The output register lets the next item be taken while the final
//   result of the previous one waits.
// Reset: rst (synchronous) clears the held-prefix count, drops any pending
//   output and restores pattern/replacement to one zero byte each.
// Stall: when out_ready is low the emit sequence pauses; no bytes lost.
// Config: cfg_we writes cfg_data to register cfg_index; write only idle.
`default_nettype none

module stream_find_replace_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [63:0] cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  data_byte,
  input  wire         end_of_stream,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        stream_last
);
  import sfr_pkg::*;

  sfr_cmd_t    cmd;
  sfr_status_t status;
  logic        in_fire;

  assign in_fire = in_valid && in_ready;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sfr_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .cmd           (cmd),
    .status        (status),
    .out_byte      (out_byte),
    .run_last      (run_last),
    .stream_last   (stream_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

endmodule

`default_nettype wire

// ----- rtl/sfr_checker.sv -----
// Port-level checks for stream_find_replace_top, attached by bind.
// Depends on the top level's port list only.
`default_nettype none

module sfr_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [7:0]  out_byte,
  input wire        run_last,
  input wire        stream_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
    else $error("stalled output changed");

  // the stream end is always the end of an item's run
  a_stream_last_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_last |-> run_last)
    else $error("stream_last without run_last");

  // an accepted item is searched before another is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind stream_find_replace_top sfr_checker u_sfr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .run_last    (run_last),
  .stream_last (stream_last)
);

`default_nettype wire

// ----- verif/stream_find_replace_top_tb.sv -----
// Testbench for stream_find_replace_top: directed and random text streams checked
// byte by byte against a find-and-replace predictor held in a scoreboard class.
// Depends on sfr_pkg and the stream_find_replace_top RTL.

typedef struct {
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_last;
} sfr_result_t;

// Mirrors the register file and the held-prefix count, and keeps the
// rewritten bytes that are still owed by the block.
class sfr_rewrite_board;
  logic [63:0]   pattern_bytes;
  logic [3:0]    pattern_length;
  logic [63:0]   replacement_bytes;
  logic [3:0]    replacement_length;
  logic [3:0]    held_count;
  sfr_result_t   owed_bytes[$];
  int unsigned   failures;
  int unsigned   bytes_checked;
  int unsigned   swaps;
  int unsigned   flushes;

  function new();
    pattern_bytes      = '0;
    pattern_length     = 4'd1;
    replacement_bytes  = '0;
    replacement_length = 4'd1;
    held_count         = '0;
    failures           = 0;
    bytes_checked      = 0;
    swaps              = 0;
    flushes            = 0;
  endfunction

  function void write_reg(sfr_pkg::sfr_reg_t index, logic [63:0] value);
    case (index)
      sfr_pkg::REG_PATTERN_BYTES:      pattern_bytes      = value;
      sfr_pkg::REG_PATTERN_LENGTH:     pattern_length     = value[3:0];
      sfr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes  = value;
      sfr_pkg::REG_REPLACEMENT_LENGTH: replacement_length = value[3:0];
      default: ;
    endcase
  endfunction

  // zero acts as one, oversize saturates
  function int unsigned span_of(logic [3:0] len, int unsigned cap);
    if (len == 0) return 1;
    if (len > cap) return cap;
    return len;
  endfunction

  function logic [7:0] pattern_at(int unsigned i);
    return pattern_bytes[8 * (i % 8) +: 8];
  endfunction

  function logic [7:0] replacement_at(int unsigned i);
    return replacement_bytes[8 * (i % 8) +: 8];
  endfunction

  // Accepted input item: work out the bytes it releases.
  function void note_input(logic [7:0] text_byte, logic eos);
    int unsigned plen = span_of(pattern_length, sfr_pkg::MAX_PATTERN);
    int unsigned rlen = span_of(replacement_length, sfr_pkg::MAX_REPLACEMENT);
    int unsigned keep = held_count;
    int unsigned start = 0;
    int unsigned span;
    int unsigned i;
    bit          whole;
    logic [7:0]  window[$];
    logic [7:0]  emitted[$];
    sfr_result_t r;

    // pattern may have shrunk while a prefix was held
    if (keep >= plen) keep = plen - 1;
    for (i = 0; i < keep; i++) window.push_back(pattern_at(i));

    if (text_byte == sfr_pkg::NEWLINE_BYTE) begin
      emitted = window;
      emitted.push_back(text_byte);
      keep = 0;
    end else begin
      window.push_back(text_byte);
      keep = 0;
      // naive rescan, one start position at a time
      while (start < window.size()) begin
        span  = window.size() - start;
        whole = 1'b1;
        for (i = 0; i < span; i++) begin
          if (window[start + i] != pattern_at(i)) begin
            whole = 1'b0;
            break;
          end
        end
        if (whole) begin
          if (span == plen) begin
            for (i = 0; i < rlen; i++) emitted.push_back(replacement_at(i));
            swaps++;
          end else begin
            keep = span;
          end
          break;
        end
        emitted.push_back(window[start]);
        start++;
      end
    end

    if (eos) begin
      for (i = 0; i < keep; i++) emitted.push_back(pattern_at(i));
      keep = 0;
      flushes++;
    end
    held_count = keep[3:0];

    foreach (emitted[k]) begin
      r.out_byte    = emitted[k];
      r.run_last    = (k == emitted.size() - 1);
      r.stream_last = r.run_last && eos;
      owed_bytes.push_back(r);
    end
  endfunction

  function void check_result(logic [7:0] b, logic rl, logic sl);
    sfr_result_t want;
    if (owed_bytes.size() == 0) begin
      $error("output byte %02h arrived with nothing owed", b);
      failures++;
      return;
    end
    want = owed_bytes.pop_front();
    bytes_checked++;
    if (b !== want.out_byte) begin
      $error("out_byte: expected %02h, actual %02h", want.out_byte, b);
      failures++;
    end
    if (rl !== want.run_last) begin
      $error("run_last: expected %0b, actual %0b", want.run_last, rl);
      failures++;
    end
    if (sl !== want.stream_last) begin
      $error("stream_last: expected %0b, actual %0b", want.stream_last, sl);
      failures++;
    end
  endfunction
endclass

module stream_find_replace_top_tb;
  import sfr_pkg::*;

  // Settle margin covers the worst item: its load, search steps and emits, rounded up.
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned IDLE_PERCENT    = 32;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned PHASE_ITEMS     = 40;

  // Opening script, {end_of_stream, data_byte}, pattern "aab".
  localparam logic [8:0] OPENING_SCRIPT [16] = '{
    9'h061, 9'h061, 9'h062,           // straight match, 8-byte replacement
    9'h061, 9'h061, 9'h061, 9'h062,   // longer run: oldest byte released, then match
    9'h061, 9'h062,                   // prefix broken on the second byte
    9'h061, 9'h00A,                   // newline cancels a held byte
    9'h000, 9'h0FF,                   // byte extremes
    9'h061, 9'h161,                   // end of stream flushes a held prefix
    9'h178                            // end of stream with nothing held
  };

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_we        = 1'b0;
  sfr_reg_t    cfg_index     = REG_PATTERN_BYTES;
  logic [63:0] cfg_data      = '0;
  logic        in_valid      = 1'b0;
  logic [7:0]  data_byte     = '0;
  logic        end_of_stream = 1'b0;
  logic        out_ready     = 1'b0;
  wire         in_ready;
  wire         out_valid;
  wire  [7:0]  out_byte;
  wire         run_last;
  wire         stream_last;

  // Idling controls, flipped by the main sequence between phases.
  bit          sender_idles     = 1'b1;
  bit          receiver_idles   = 1'b1;
  bit          hold_off_request = 1'b0;
  logic [7:0]  alphabet[3];
  int unsigned settings_used = 0;
  int unsigned items_sent    = 0;
  sfr_rewrite_board board;

  stream_find_replace_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .run_last      (run_last),
    .stream_last   (stream_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Output side. Values read at the edge are the pre-edge ones, so the
  // handshake seen here is exactly the one the block sees.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result(out_byte, run_last, stream_last);
  end

  // Receiver: random back-pressure, plus one long hold-off counted here
  // so the block fills up and stops taking input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= !receiver_idles || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Offer one item; returns at the edge where it is taken. Valid stays up
  // so a following item can go out back to back.
  task automatic send_item(logic [7:0] b, logic eos);
    while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(b, eos);
    items_sent++;
  endtask

  // Stop offering, wait for every owed byte, then let a held item settle.
  task automatic finish_burst();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.owed_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; write_all_regs drops it after the last one.
  task automatic write_one(sfr_reg_t index, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    board.write_reg(index, value);
  endtask

  // Length registers get random junk above the low nibble.
  task automatic write_all_regs(logic [63:0] pat, logic [3:0] plen,
                                logic [63:0] rep, logic [3:0] rlen);
    logic [63:0] noise = {$urandom, $urandom};
    write_one(REG_PATTERN_BYTES, pat);
    write_one(REG_PATTERN_LENGTH, {noise[63:4], plen});
    write_one(REG_REPLACEMENT_BYTES, rep);
    write_one(REG_REPLACEMENT_LENGTH, {noise[59:0], rlen});
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Pattern drawn from a three-letter alphabet so that overlaps and
  // partial matches are common; bytes past the length stay random.
  task automatic configure(logic [3:0] plen, logic [3:0] rlen, bit newline_in_pattern);
    logic [63:0] pat = {$urandom, $urandom};
    int unsigned span;
    int unsigned i;
    for (i = 0; i < 3; i++) begin
      do alphabet[i] = 8'($urandom_range(255));
      while (alphabet[i] == NEWLINE_BYTE);
    end
    span = board.span_of(plen, MAX_PATTERN);
    for (i = 0; i < span; i++) pat[8 * i +: 8] = alphabet[$urandom_range(2)];
    if (newline_in_pattern) pat[8 * $urandom_range(span - 1) +: 8] = NEWLINE_BYTE;
    write_all_regs(pat, plen, {$urandom, $urandom}, rlen);
  endtask

  // Mostly whole or partial copies of the pattern, with alphabet letters,
  // newlines, replacement bytes and full-range noise mixed in.
  task automatic random_text(int unsigned count, bit close_stream);
    logic [7:0]  text[$];
    int unsigned span = board.span_of(board.pattern_length, MAX_PATTERN);
    int unsigned i;
    int unsigned cut;
    while (text.size() < count) begin
      case ($urandom_range(9))
        0, 1, 2: for (i = 0; i < span; i++) text.push_back(board.pattern_at(i));
        3, 4: begin
          cut = $urandom_range(span);
          for (i = 0; i < cut; i++) text.push_back(board.pattern_at(i));
        end
        5, 6: text.push_back(alphabet[$urandom_range(2)]);
        7: text.push_back(NEWLINE_BYTE);
        8: text.push_back(8'($urandom_range(255)));
        default: text.push_back(board.replacement_at($urandom_range(7)));
      endcase
    end
    for (i = 0; i < text.size(); i++)
      send_item(text[i], (close_stream && i == text.size() - 1) || $urandom_range(39) == 0);
  endtask

  initial begin
    int unsigned ph;
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    write_all_regs(64'h0000_0000_0062_6161, 4'd3, 64'hFF00_5A5A_A5A5_00FF, 4'd8);
    foreach (OPENING_SCRIPT[k]) send_item(OPENING_SCRIPT[k][7:0], OPENING_SCRIPT[k][8]);
    finish_burst();

    // Leave "aa" held, then shrink the pattern under it: the held count is
    // cut back and the held byte is read from the new pattern.
    send_item(8'h61, 1'b0);
    send_item(8'h61, 1'b0);
    finish_burst();
    write_all_regs(64'h0000_0000_0000_6161, 4'd2, 64'h0123_4567_89AB_CDEF, 4'd15);
    send_item(8'h71, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h61, 1'b1);
    finish_burst();

    // zero lengths behave as one
    write_all_regs(64'h8000_0000_0000_00FF, 4'd0, 64'h0000_0000_0000_0000, 4'd0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    finish_burst();

    // newline inside the pattern: never matches, the newline wins
    write_all_regs(64'h0000_0000_0000_0A61, 4'd2, 64'h0000_0000_0000_7A7A, 4'd2);
    send_item(8'h61, 1'b0);
    send_item(NEWLINE_BYTE, 1'b0);
    send_item(8'h61, 1'b1);
    finish_burst();

    // --- random phases ---
    // Some phases end with a prefix still held, so the next register
    // change lands mid-match. Phase 4 runs with no idling on either side.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      sender_idles   = (ph != 4);
      receiver_idles = (ph != 4);
      case (ph)
        0: configure(4'd8, 4'd8, 1'b0);
        1: configure(4'd1, 4'd1, 1'b0);
        2: configure(4'd0, 4'd15, 1'b0);
        3: configure(4'd3, 4'($urandom_range(1, 8)), 1'b1);
        default: configure(4'($urandom_range(2, 6)), 4'($urandom_range(1, 8)), 1'b0);
      endcase
      if (ph == 6) hold_off_request = 1'b1;
      random_text(PHASE_ITEMS, (ph % 3) != 2);
      finish_burst();
    end

    $display("Ran %0d items through %0d register settings, %0d output bytes checked.",
             items_sent, settings_used, board.bytes_checked);
    $display("Streams saw %0d replacements and %0d end-of-stream flushes.",
             board.swaps, board.flushes);
    if (board.failures == 0 && board.owed_bytes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sfr_pkg.sv
rtl/sfr_ctrl.sv
rtl/sfr_datapath.sv
rtl/stream_find_replace_top.sv
rtl/sfr_checker.sv
verif/stream_find_replace_top_tb.sv
